[hw/rtl/hio_pkg.sv]
// Shared constants and functions for the handheld I/O page block.
`timescale 1ns / 1ps
package hio_pkg;
    localparam int IO_COUNT_DEF = 76;
    localparam int HRAM_DEPTH   = 127;
    localparam int HRAM_AW      = 7;

    localparam logic [2:0] K_READ    = 3'd0;
    localparam logic [2:0] K_WRITE   = 3'd1;
    localparam logic [2:0] K_DIV     = 3'd2;
    localparam logic [2:0] K_TIMA    = 3'd3;
    localparam logic [2:0] K_LY      = 3'd4;
    localparam logic [2:0] K_MODE    = 3'd5;
    localparam logic [2:0] K_PRESS   = 3'd6;
    localparam logic [2:0] K_RELEASE = 3'd7;

    localparam logic [6:0] OFS_JOYP = 7'h00;
    localparam logic [6:0] OFS_DIV  = 7'h04;
    localparam logic [6:0] OFS_TIMA = 7'h05;
    localparam logic [6:0] OFS_TMA  = 7'h06;
    localparam logic [6:0] OFS_TAC  = 7'h07;
    localparam logic [6:0] OFS_IF   = 7'h0F;
    localparam logic [6:0] OFS_STAT = 7'h41;
    localparam logic [6:0] OFS_LY   = 7'h44;
    localparam logic [6:0] OFS_LYC  = 7'h45;
    localparam logic [6:0] OFS_DMA  = 7'h46;
    localparam logic [7:0] LY_LINES = 8'd154;

    function automatic logic [7:0] t_io_reset(input logic [6:0] ofs);
        case (ofs)
            7'h10: t_io_reset = 8'h80;
            7'h11: t_io_reset = 8'hBF;
            7'h12: t_io_reset = 8'hF3;
            7'h14: t_io_reset = 8'hBF;
            7'h16: t_io_reset = 8'h3F;
            7'h19: t_io_reset = 8'hBF;
            7'h1A: t_io_reset = 8'h7F;
            7'h1B: t_io_reset = 8'hFF;
            7'h1C: t_io_reset = 8'h9F;
            7'h1E: t_io_reset = 8'hBF;
            7'h20: t_io_reset = 8'hFF;
            7'h23: t_io_reset = 8'hBF;
            7'h24: t_io_reset = 8'h77;
            7'h25: t_io_reset = 8'hF3;
            7'h26: t_io_reset = 8'hF1;
            7'h40: t_io_reset = 8'h91;
            7'h47: t_io_reset = 8'hFC;
            7'h48: t_io_reset = 8'hFF;
            7'h49: t_io_reset = 8'hFF;
            default: t_io_reset = 8'h00;
        endcase
    endfunction
endpackage

[hw/rtl/hio_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module hio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/handheld_io_register_block.sv]
// Top level of the handheld high I/O page: I/O registers, high RAM, IE.
//
// Usage: one event item per cycle on the input channel (kind, address,
// write data, LCD mode, button) while o_stall is low. Each item yields
// exactly one result item with the read byte, the mapped flag and the
// current TAC timer fields. An item goes into the pipe register at its
// accept edge, then on into the output register. Throughput: one item a
// cycle when the receiver does not stall, set by the single read port of
// each RAM; the few I/O registers that events touch are flops, the rest of
// the I/O page and the high RAM are RAMs read at the accept edge, with the
// byte picked up next cycle. A RAM write lands at its accept edge, before
// any later read. When the receiver stalls a waiting result, the input
// still takes one more item into a skid register, then stalls in turn.
// Reset (synchronous, active low) restores the hot registers, clears IE
// and held buttons and empties the output side; then the I/O RAM is loaded
// from the power-on table, one entry a cycle, with o_stall high until all
// IO_COUNT entries (76 by default) are written. High RAM is not cleared;
// a read of a never-written entry returns an undefined byte.
`timescale 1ns / 1ps
module handheld_io_register_block
    import hio_pkg::*;
#(
    parameter int IO_COUNT = IO_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_lcd_mode,
    input  logic [2:0]  i_button,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_mapped,
    output logic        o_timer_enable,
    output logic [1:0]  o_timer_clock
);
    // Registers that events modify stay in flops; the rest of the page is RAM.
    logic [7:0] r_joyp, r_div, r_tima, r_tma, r_tac, r_if, r_stat, r_ly, r_lyc;
    logic [7:0] r_ie, r_btn;
    logic       r_init;
    logic [6:0] r_init_addr;

    logic accept;
    assign accept = i_valid && !o_stall;

    // Address decode
    logic [6:0] ofs;
    logic is_io, is_hram, is_ie, is_acc;
    assign ofs     = i_address[6:0];
    assign is_io   = (i_address[15:7] == 9'h1FE) && (32'(ofs) < IO_COUNT);
    assign is_hram = (i_address[15:7] == 9'h1FF) && (ofs != 7'h7F);
    assign is_ie   = (i_address == 16'hFFFF);
    assign is_acc  = (i_kind == K_READ) || (i_kind == K_WRITE);

    logic       io_hot;
    logic [7:0] hot_rd;
    always_comb begin
        io_hot = 1'b1;
        hot_rd = 8'h00;
        unique case (ofs)
            OFS_JOYP: hot_rd = r_joyp;
            OFS_DIV:  hot_rd = r_div;
            OFS_TIMA: hot_rd = r_tima;
            OFS_TMA:  hot_rd = r_tma;
            OFS_TAC:  hot_rd = r_tac;
            OFS_IF:   hot_rd = r_if;
            OFS_STAT: hot_rd = r_stat;
            OFS_LY:   hot_rd = r_ly;
            OFS_LYC:  hot_rd = r_lyc;
            default:  io_hot = 1'b0;
        endcase
    end

    // I/O RAM: loaded from the power-on table after reset
    logic       io_we;
    logic [6:0] io_waddr;
    logic [7:0] io_wdata, io_rd, hram_rd;
    assign io_we    = r_init || (accept && i_kind == K_WRITE && is_io && !io_hot
                                 && ofs != OFS_DMA);
    assign io_waddr = r_init ? r_init_addr : ofs;
    assign io_wdata = r_init ? t_io_reset(r_init_addr) : i_write_data;

    hio_ram #(.WIDTH(8), .DEPTH(IO_COUNT)) u_io (
        .i_clk  (i_clk),
        .i_we   (io_we),
        .i_waddr(io_waddr),
        .i_wdata(io_wdata),
        .i_raddr(ofs),
        .o_rdata(io_rd)
    );

    // High RAM, registered read
    hio_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
        .i_clk  (i_clk),
        .i_we   (accept && i_kind == K_WRITE && is_hram),
        .i_waddr(ofs),
        .i_wdata(i_write_data),
        .i_raddr(ofs),
        .o_rdata(hram_rd)
    );

    // Next state of the hot registers
    logic [7:0] n_joyp, n_div, n_tima, n_tma, n_tac, n_if, n_stat, n_ly, n_lyc;
    logic [7:0] n_ie, n_btn;
    logic [7:0] sel, pressed, ly, st, fl;
    always_comb begin
        n_joyp = r_joyp; n_div = r_div; n_tima = r_tima; n_tma = r_tma;
        n_tac = r_tac; n_if = r_if; n_stat = r_stat; n_ly = r_ly; n_lyc = r_lyc;
        n_ie = r_ie;
        n_btn = r_btn;
        sel = 8'h00; pressed = 8'h00; ly = 8'h00; st = 8'h00; fl = 8'h00;
        if (accept) begin
            case (i_kind)
                K_READ: ;
                K_WRITE: begin
                    if (is_ie) n_ie = i_write_data;
                    else if (is_io) begin
                        case (ofs) inside
                            OFS_JOYP: begin
                                sel = i_write_data & 8'hF0;
                                if (sel == 8'h20) pressed = {4'h0, r_btn[3:0]};
                                else if (sel == 8'h10) pressed = {4'h0, r_btn[7:4]};
                                n_joyp = sel | (8'h0F & ~pressed);
                            end
                            OFS_DIV: n_div = 8'h00;
                            OFS_TIMA, OFS_LY, OFS_DMA: ;
                            OFS_STAT: begin
                                if ((i_write_data & 8'hF8) != 8'h00) n_ie = r_ie | 8'h02;
                                n_stat = (i_write_data & 8'hF8) | (r_stat & 8'h07);
                            end
                            OFS_TMA: n_tma = i_write_data;
                            OFS_TAC: n_tac = i_write_data;
                            OFS_IF:  n_if  = i_write_data;
                            OFS_LYC: n_lyc = i_write_data;
                            default: ;
                        endcase
                    end
                end
                K_DIV: n_div = r_div + 8'd1;
                K_TIMA: begin
                    if (r_tima == 8'hFF) begin
                        n_tima = r_tma;
                        n_if = r_if | 8'h04;
                    end else begin
                        n_tima = r_tima + 8'd1;
                    end
                end
                K_LY: begin
                    ly = r_ly + 8'd1;
                    if (ly >= LY_LINES) ly = 8'h00;
                    n_ly = ly;
                    if (ly == r_lyc) begin
                        n_stat = r_stat | 8'h04;
                        if (r_stat[6]) n_if = r_if | 8'h02;
                    end else begin
                        n_stat = r_stat & 8'hFB;
                    end
                end
                K_MODE: begin
                    st = {r_stat[7:2], i_lcd_mode};
                    fl = r_if;
                    case (i_lcd_mode)
                        2'd0: if (st[3]) fl = fl | 8'h02;
                        2'd1: begin
                            fl = fl | 8'h01;
                            if (st[4]) fl = fl | 8'h02;
                        end
                        2'd2: if (st[5]) fl = fl | 8'h02;
                        default: ;
                    endcase
                    n_stat = st;
                    n_if = fl;
                end
                K_PRESS: begin
                    n_btn = r_btn | (8'h01 << i_button);
                    n_if = r_if | 8'h10;
                end
                default: n_btn = r_btn & ~(8'h01 << i_button);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joyp <= t_io_reset(OFS_JOYP);
            r_div  <= t_io_reset(OFS_DIV);
            r_tima <= t_io_reset(OFS_TIMA);
            r_tma  <= t_io_reset(OFS_TMA);
            r_tac  <= t_io_reset(OFS_TAC);
            r_if   <= t_io_reset(OFS_IF);
            r_stat <= t_io_reset(OFS_STAT);
            r_ly   <= t_io_reset(OFS_LY);
            r_lyc  <= t_io_reset(OFS_LYC);
            r_ie   <= 8'h00;
            r_btn  <= 8'h00;
            r_init <= 1'b1;
            r_init_addr <= 7'd0;
        end else begin
            r_joyp <= n_joyp;
            r_div  <= n_div;
            r_tima <= n_tima;
            r_tma  <= n_tma;
            r_tac  <= n_tac;
            r_if   <= n_if;
            r_stat <= n_stat;
            r_ly   <= n_ly;
            r_lyc  <= n_lyc;
            r_ie   <= n_ie;
            r_btn  <= n_btn;
            if (r_init) begin
                if (r_init_addr == 7'(IO_COUNT - 1)) r_init <= 1'b0;
                r_init_addr <= r_init_addr + 7'd1;
            end
        end
    end

    // Pipe stage plus output register with skid: o_stall while the I/O RAM loads,
    // or when output full and pipe holds an item that cannot move.
    logic       r_p_valid, r_p_io, r_p_hr;
    logic [7:0] r_p_data;
    logic       r_p_mapped, r_p_te;
    logic [1:0] r_p_tc;

    logic [7:0] pipe_data;
    assign pipe_data = r_p_hr ? hram_rd : r_p_io ? io_rd : r_p_data;

    logic       r_o_valid;
    logic [7:0] r_o_data;
    logic       r_o_mapped, r_o_te;
    logic [1:0] r_o_tc;
    logic       pipe_move;

    assign pipe_move = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall   = r_init || (r_p_valid && !pipe_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) r_p_valid <= 1'b1;
            else if (pipe_move) r_p_valid <= 1'b0;
            if (pipe_move) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
        if (accept) begin
            r_p_io     <= (i_kind == K_READ) && is_io && !io_hot;
            r_p_hr     <= (i_kind == K_READ) && is_hram;
            r_p_data   <= (i_kind != K_READ) ? 8'h00 :
                          (is_io && io_hot) ? hot_rd : is_ie ? r_ie : 8'h00;
            r_p_mapped <= is_acc && (is_io || is_hram || is_ie);
            r_p_te     <= n_tac[2];
            r_p_tc     <= n_tac[1:0];
        end else if (r_p_valid && !pipe_move && (r_p_io || r_p_hr)) begin
            // RAM data is there only the cycle after the read; hold it
            r_p_data <= pipe_data;
            r_p_io   <= 1'b0;
            r_p_hr   <= 1'b0;
        end
        if (pipe_move) begin
            r_o_data   <= pipe_data;
            r_o_mapped <= r_p_mapped;
            r_o_te     <= r_p_te;
            r_o_tc     <= r_p_tc;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_read_data    = r_o_data;
    assign o_mapped       = r_o_mapped;
    assign o_timer_enable = r_o_te;
    assign o_timer_clock  = r_o_tc;
endmodule

[tb/handheld_io_register_block_tb.sv]
// Self-checking testbench for the handheld high I/O page block.
`timescale 1ns / 1ps
module handheld_io_register_block_tb;
    import hio_pkg::*;

    localparam int IO_N = IO_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       mapped;
        logic       timer_enable;
        logic [1:0] timer_clock;
    } t_io_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_kind = K_READ;
    logic [15:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic [1:0]  i_lcd_mode = '0;
    logic [2:0]  i_button = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_mapped;
    logic        o_timer_enable;
    logic [1:0]  o_timer_clock;

    handheld_io_register_block uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the I/O page
    logic [7:0] io_shadow [128];
    logic [7:0] hram_shadow [HRAM_DEPTH];
    bit         hram_written [HRAM_DEPTH];
    logic [7:0] ie_shadow;
    logic [7:0] held_shadow;

    t_io_result expected_results [$];
    int  errors = 0;
    int  cycles = 0;
    int  long_hold = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  rx_wait = 0;
    bit  rx_random = 1'b0;

    function automatic void shadow_reset();
        for (int i = 0; i < 128; i++) io_shadow[i] = t_io_reset(7'(i));
        for (int i = 0; i < HRAM_DEPTH; i++) hram_written[i] = 1'b0;
        ie_shadow = '0;
        held_shadow = '0;
    endfunction

    function automatic void shadow_write(logic [6:0] ofs, logic [7:0] data);
        logic [7:0] sel;
        logic [3:0] pressed;
        sel = data & 8'hF0;
        case (ofs) inside
            OFS_JOYP: begin
                pressed = 4'h0;
                if (sel == 8'h20) pressed = held_shadow[3:0];
                else if (sel == 8'h10) pressed = held_shadow[7:4];
                io_shadow[OFS_JOYP] = sel | {4'h0, ~pressed};
            end
            OFS_DIV: io_shadow[OFS_DIV] = 8'h00;
            OFS_TIMA, OFS_LY, OFS_DMA: ;
            OFS_STAT: begin
                if ((data & 8'hF8) != 8'h00) ie_shadow[1] = 1'b1;
                io_shadow[OFS_STAT] = (data & 8'hF8) | (io_shadow[OFS_STAT] & 8'h07);
            end
            default: io_shadow[ofs] = data;
        endcase
    endfunction

    function automatic t_io_result predict_event(logic [2:0] kind, logic [15:0] addr,
                                                 logic [7:0] data, logic [1:0] mode,
                                                 logic [2:0] btn);
        t_io_result r;
        logic [7:0] v;
        r = '0;
        case (kind)
            K_READ, K_WRITE: begin
                if (addr >= 16'hFF00 && int'(addr - 16'hFF00) < IO_N) begin
                    r.mapped = 1'b1;
                    if (kind == K_READ) r.read_data = io_shadow[addr[6:0]];
                    else shadow_write(addr[6:0], data);
                end else if (addr >= 16'hFF80 && addr < 16'hFFFF) begin
                    r.mapped = 1'b1;
                    if (kind == K_READ) r.read_data = hram_shadow[addr[6:0]];
                    else begin
                        hram_shadow[addr[6:0]] = data;
                        hram_written[addr[6:0]] = 1'b1;
                    end
                end else if (addr == 16'hFFFF) begin
                    r.mapped = 1'b1;
                    if (kind == K_READ) r.read_data = ie_shadow;
                    else ie_shadow = data;
                end
            end
            K_DIV: io_shadow[OFS_DIV] = io_shadow[OFS_DIV] + 8'd1;
            K_TIMA: begin
                v = io_shadow[OFS_TIMA] + 8'd1;
                if (v == 8'd0) begin
                    io_shadow[OFS_IF][2] = 1'b1;
                    v = io_shadow[OFS_TMA];
                end
                io_shadow[OFS_TIMA] = v;
            end
            K_LY: begin
                v = io_shadow[OFS_LY] + 8'd1;
                if (v >= LY_LINES) v = 8'd0;
                io_shadow[OFS_LY] = v;
                if (v == io_shadow[OFS_LYC]) begin
                    io_shadow[OFS_STAT][2] = 1'b1;
                    if (io_shadow[OFS_STAT][6]) io_shadow[OFS_IF][1] = 1'b1;
                end else io_shadow[OFS_STAT][2] = 1'b0;
            end
            K_MODE: begin
                io_shadow[OFS_STAT][1:0] = mode;
                case (mode)
                    2'd0: if (io_shadow[OFS_STAT][3]) io_shadow[OFS_IF][1] = 1'b1;
                    2'd1: begin
                        io_shadow[OFS_IF][0] = 1'b1;
                        if (io_shadow[OFS_STAT][4]) io_shadow[OFS_IF][1] = 1'b1;
                    end
                    2'd2: if (io_shadow[OFS_STAT][5]) io_shadow[OFS_IF][1] = 1'b1;
                    default: ;
                endcase
            end
            K_PRESS: begin
                held_shadow[btn] = 1'b1;
                io_shadow[OFS_IF][4] = 1'b1;
            end
            default: held_shadow[btn] = 1'b0;
        endcase
        r.timer_enable = io_shadow[OFS_TAC][2];
        r.timer_clock = io_shadow[OFS_TAC][1:0];
        return r;
    endfunction

    // one item: optional random gap, then hold until accepted; valid stays up after
    // acceptance so that a next item without gap follows at once
    task automatic send_event(logic [2:0] kind, logic [15:0] addr, logic [7:0] data,
                              logic [1:0] mode, logic [2:0] btn, bit gaps = 1'b1);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12))) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_address <= addr;
        i_write_data <= data;
        i_lcd_mode <= mode;
        i_button <= btn;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_event(kind, addr, data, mode, btn));
    endtask

    // address that never reads unwritten high RAM
    function automatic logic [15:0] pick_address(bit is_read);
        logic [15:0] a;
        case ($urandom_range(0, 5))
            0, 1: a = 16'hFF00 + 16'($urandom_range(0, 127));
            2: a = 16'hFF80 + 16'($urandom_range(0, 126));
            3: a = 16'hFFFF;
            4: a = 16'h0000 + 16'($urandom_range(0, 16'hFEFF));
            default: a = 16'($urandom);
        endcase
        if (is_read && a >= 16'hFF80 && a < 16'hFFFF && !hram_written[a[6:0]])
            a = 16'hFF80 + 16'($urandom_range(0, 126));
        if (is_read && a >= 16'hFF80 && a < 16'hFFFF && !hram_written[a[6:0]])
            a = 16'hFFFF;
        return a;
    endfunction

    task automatic test_io_page_read();
        for (int i = 0; i < 128; i += 9) send_event(K_READ, 16'hFF00 + 16'(i), '0, '0, '0);
        send_event(K_READ, 16'hFF00 + 16'(IO_N - 1), '0, '0, '0);
        send_event(K_READ, 16'hFF00 + 16'(IO_N), '0, '0, '0);
        send_event(K_READ, 16'h0000, '0, '0, '0);
        send_event(K_READ, 16'hFEFF, '0, '0, '0);
    endtask

    task automatic test_special_writes();
        send_event(K_PRESS, '0, '0, '0, 3'd0);
        send_event(K_PRESS, '0, '0, '0, 3'd7);
        send_event(K_WRITE, 16'hFF00, 8'h20, '0, '0);
        send_event(K_READ, 16'hFF00, '0, '0, '0);
        send_event(K_WRITE, 16'hFF00, 8'h1F, '0, '0);
        send_event(K_READ, 16'hFF00, '0, '0, '0);
        send_event(K_WRITE, 16'hFF04, 8'hFF, '0, '0);
        send_event(K_WRITE, 16'hFF05, 8'hAA, '0, '0);
        send_event(K_WRITE, 16'hFF44, 8'h55, '0, '0);
        send_event(K_WRITE, 16'hFF46, 8'h12, '0, '0);
        send_event(K_WRITE, 16'hFF07, 8'hFF, '0, '0);
        send_event(K_WRITE, 16'hFF41, 8'hFF, '0, '0);
        send_event(K_WRITE, 16'hFF80, 8'h00, '0, '0);
        send_event(K_WRITE, 16'hFFFE, 8'hFF, '0, '0);
        send_event(K_READ, 16'hFFFE, '0, '0, '0);
        send_event(K_READ, 16'hFFFF, '0, '0, '0);
        send_event(K_WRITE, 16'hFFFF, 8'hA5, '0, '0);
        send_event(K_WRITE, 16'hFF0F, 8'h00, '0, '0);
        for (int m = 0; m < 4; m++) send_event(K_MODE, '0, '0, 2'(m), '0);
        send_event(K_RELEASE, '0, '0, '0, 3'd7);
    endtask

    task automatic test_tima_overflow();
        send_event(K_WRITE, 16'hFF06, 8'hF0, '0, '0, 1'b0);
        for (int i = 0; i < 300; i++) send_event(K_TIMA, '0, '0, '0, '0, 1'b0);
        send_event(K_READ, 16'hFF0F, '0, '0, '0);
    endtask

    task automatic test_ly_coincidence();
        send_event(K_WRITE, 16'hFF45, 8'd5, '0, '0, 1'b0);
        for (int i = 0; i < 160; i++) send_event(K_LY, '0, '0, '0, '0, 1'b0);
        send_event(K_READ, 16'hFF41, '0, '0, '0);
        send_event(K_READ, 16'hFF0F, '0, '0, '0);
    endtask

    task automatic test_random_events(int count);
        logic [2:0] k;
        for (int n = 0; n < count; n++) begin
            k = 3'($urandom);
            if (k == K_READ || k == K_WRITE) begin
                send_event(k, pick_address(k == K_READ), 8'($urandom), 2'($urandom),
                           3'($urandom));
            end else begin
                send_event(k, 16'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_seq++;
        for (int i = 0; i < 20; i++)
            send_event(K_READ, 16'hFF00 + 16'(i), '0, '0, '0, 1'b0);
    endtask

    // receiver: long hold on request, else (with rx_random) a drawn wait after each result
    always @(posedge i_clk) begin
        int w;
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            long_hold <= 40;
            i_stall <= 1'b1;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= 1'b1;
        end else if (rx_random && o_valid && !i_stall) begin
            w = int'($urandom_range(0, 12));
            i_stall <= (w > 0);
            rx_wait <= (w > 0) ? w - 1 : 0;
        end else i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_io_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no expected item");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_read_data !== exp_r.read_data) begin
                    $error("read_data exp %h got %h", exp_r.read_data, o_read_data);
                    errors++;
                end
                if (o_mapped !== exp_r.mapped) begin
                    $error("mapped exp %b got %b", exp_r.mapped, o_mapped);
                    errors++;
                end
                if (o_timer_enable !== exp_r.timer_enable) begin
                    $error("timer_enable exp %b got %b", exp_r.timer_enable, o_timer_enable);
                    errors++;
                end
                if (o_timer_clock !== exp_r.timer_clock) begin
                    $error("timer_clock exp %h got %h", exp_r.timer_clock, o_timer_clock);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        shadow_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_io_page_read();
        test_special_writes();
        test_tima_overflow();
        test_ly_coincidence();
        rx_random = 1'b1;
        test_backpressure();
        test_random_events(350);
        rx_random = 1'b0;
        test_random_events(50);
        rx_random = 1'b1;
        test_random_events(225);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
